[rtl/tow_pkg.sv]
// Package with the shared types, codes and helpers of the TCP option walker.
`timescale 1ns / 1ps

package tow_pkg;

    // Default limit on the option area size in bytes.
    localparam int MAX_OPT_BYTES_DEF = 40;

    // Option kind bytes with a class of their own.
    localparam logic [7:0] KIND_EOL       = 8'd0;
    localparam logic [7:0] KIND_NOP       = 8'd1;
    localparam logic [7:0] KIND_MSS       = 8'd2;
    localparam logic [7:0] KIND_WSCALE    = 8'd3;
    localparam logic [7:0] KIND_SACK_PERM = 8'd4;
    localparam logic [7:0] KIND_SACK      = 8'd5;
    localparam logic [7:0] KIND_TSTAMP    = 8'd8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_KIND = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CLS_EOL       = 3'd0,
        CLS_NOP       = 3'd1,
        CLS_MSS       = 3'd2,
        CLS_WSCALE    = 3'd3,
        CLS_SACK_PERM = 3'd4,
        CLS_SACK      = 3'd5,
        CLS_TSTAMP    = 3'd6,
        CLS_UNKNOWN   = 3'd7
    } kind_class_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_EXCEEDS  = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    // One registered input beat as the walker sees it.
    typedef struct packed {
        logic       valid;
        logic [7:0] opt_byte;
        logic       first_byte;
        logic [5:0] area_len;
    } beat_t;

    // One option report, with its valid flag.
    typedef struct packed {
        logic        valid;
        logic [7:0]  option_kind;
        kind_class_t kind_class;
        logic [7:0]  option_len;
        status_t     status;
        logic        ends_area;
    } rpt_t;

    function automatic kind_class_t classify(input logic [7:0] kind);
        kind_class_t cls;
        case (kind)
            KIND_EOL:       cls = CLS_EOL;
            KIND_NOP:       cls = CLS_NOP;
            KIND_MSS:       cls = CLS_MSS;
            KIND_WSCALE:    cls = CLS_WSCALE;
            KIND_SACK_PERM: cls = CLS_SACK_PERM;
            KIND_SACK:      cls = CLS_SACK;
            KIND_TSTAMP:    cls = CLS_TSTAMP;
            default:        cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

[rtl/tow_in_if.sv]
// Channel interface that carries option area bytes.
`timescale 1ns / 1ps

interface tow_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       first_byte;
    logic [5:0] area_len;

    modport source (output valid, output opt_byte, output first_byte, output area_len,
                    input ready);
    modport sink   (input valid, input opt_byte, input first_byte, input area_len,
                    output ready);
endinterface

[rtl/tow_out_if.sv]
// Channel interface that carries option reports.
`timescale 1ns / 1ps

interface tow_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_kind;
    logic [2:0] kind_class;
    logic [7:0] option_len;
    logic [1:0] status;
    logic       ends_area;

    modport source (output valid, output option_kind, output kind_class,
                    output option_len, output status, output ends_area, input ready);
    modport sink   (input valid, input option_kind, input kind_class,
                    input option_len, input status, input ends_area, output ready);
endinterface

[rtl/tow_in_reg.sv]
// Input register stage that captures one option byte beat.
`timescale 1ns / 1ps

module tow_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    tow_in_if.sink          opt,
    input  logic            advance,
    output tow_pkg::beat_t  beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic [5:0] alen_reg;
    logic       take;

    // The stage frees up in the same cycle that its beat moves on.
    assign opt.ready = !valid_reg || advance;
    assign take      = opt.valid && opt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= opt.opt_byte;
            first_reg <= opt.first_byte;
            alen_reg  <= opt.area_len;
        end
    end

    assign beat.valid      = valid_reg;
    assign beat.opt_byte   = byte_reg;
    assign beat.first_byte = first_reg;
    assign beat.area_len   = alen_reg;

endmodule

[rtl/tow_walker.sv]
// Option walk state and the per-byte decision logic that forms each report.
`timescale 1ns / 1ps

module tow_walker #(
    parameter int MAX_OPT_BYTES = tow_pkg::MAX_OPT_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tow_pkg::beat_t  beat,
    input  logic            advance,
    output tow_pkg::rpt_t   rpt
);

    localparam int CNT_W = $clog2(MAX_OPT_BYTES + 1);

    tow_pkg::phase_t      phase_reg;
    tow_pkg::phase_t      phase_next;
    logic [CNT_W-1:0]     left_reg;
    logic [CNT_W-1:0]     left_next;
    logic [7:0]           body_reg;
    logic [7:0]           body_next;
    logic [7:0]           kind_reg;
    logic [7:0]           kind_next;
    tow_pkg::kind_class_t cls_reg;
    tow_pkg::kind_class_t cls_next;

    // Effective state once a start byte has been applied.
    tow_pkg::phase_t      ph;
    logic [CNT_W-1:0]     left;
    logic [7:0]           body;
    logic [CNT_W-1:0]     alen_sat;
    logic [CNT_W-1:0]     left_dec;
    logic [7:0]           rem;
    logic [7:0]           body_new;
    tow_pkg::kind_class_t cls;
    logic                 empty_start;

    assign alen_sat = (beat.area_len > 6'(MAX_OPT_BYTES)) ? CNT_W'(MAX_OPT_BYTES)
                                                         : beat.area_len[CNT_W-1:0];
    assign empty_start = beat.first_byte && (alen_sat == '0);

    always_comb
    begin
        if (beat.first_byte)
        begin
            ph   = (alen_sat == '0) ? tow_pkg::PH_IDLE : tow_pkg::PH_KIND;
            left = alen_sat;
            body = 8'd0;
        end
        else
        begin
            ph   = phase_reg;
            left = left_reg;
            body = body_reg;
        end
    end

    assign cls      = tow_pkg::classify(beat.opt_byte);
    assign left_dec = left - CNT_W'(1);
    // Bytes still available for the option, counting its kind byte.
    assign rem      = 8'(left) + 8'd1;
    assign body_new = beat.opt_byte - 8'd2;

    // Next state.
    always_comb
    begin
        phase_next = ph;
        left_next  = left;
        body_next  = body;
        kind_next  = kind_reg;
        cls_next   = cls_reg;
        case (ph)
            tow_pkg::PH_KIND:
            begin
                if (left == '0)
                begin
                    phase_next = tow_pkg::PH_IDLE;
                    body_next  = 8'd0;
                end
                else if (cls == tow_pkg::CLS_EOL || cls == tow_pkg::CLS_NOP)
                begin
                    left_next  = left_dec;
                    phase_next = (left_dec == '0) ? tow_pkg::PH_IDLE : tow_pkg::PH_KIND;
                end
                else if (left == CNT_W'(1))
                begin
                    phase_next = tow_pkg::PH_IDLE;
                    left_next  = '0;
                    body_next  = 8'd0;
                end
                else
                begin
                    kind_next  = beat.opt_byte;
                    cls_next   = cls;
                    left_next  = left_dec;
                    phase_next = tow_pkg::PH_LEN;
                end
            end
            tow_pkg::PH_LEN:
            begin
                if (left == '0 || beat.opt_byte < 8'd2 || beat.opt_byte > rem)
                begin
                    phase_next = tow_pkg::PH_IDLE;
                    left_next  = '0;
                    body_next  = 8'd0;
                end
                else
                begin
                    left_next = left_dec;
                    body_next = body_new;
                    if (body_new == 8'd0)
                    begin
                        phase_next = (left_dec == '0) ? tow_pkg::PH_IDLE : tow_pkg::PH_KIND;
                    end
                    else
                    begin
                        phase_next = tow_pkg::PH_BODY;
                    end
                end
            end
            tow_pkg::PH_BODY:
            begin
                if (left == '0 || body == 8'd0)
                begin
                    phase_next = tow_pkg::PH_IDLE;
                    left_next  = '0;
                    body_next  = 8'd0;
                end
                else
                begin
                    left_next = left_dec;
                    body_next = body - 8'd1;
                    if (body == 8'd1)
                    begin
                        phase_next = (left_dec == '0) ? tow_pkg::PH_IDLE : tow_pkg::PH_KIND;
                    end
                end
            end
            default:
            begin
                phase_next = tow_pkg::PH_IDLE;
            end
        endcase
    end

    // Report for the current byte.
    always_comb
    begin
        rpt.valid       = 1'b0;
        rpt.option_kind = beat.opt_byte;
        rpt.kind_class  = cls;
        rpt.option_len  = 8'd1;
        rpt.status      = tow_pkg::ST_OK;
        rpt.ends_area   = 1'b0;
        case (ph)
            tow_pkg::PH_KIND:
            begin
                if (left != '0)
                begin
                    if (cls == tow_pkg::CLS_EOL || cls == tow_pkg::CLS_NOP)
                    begin
                        rpt.valid     = 1'b1;
                        rpt.ends_area = (left == CNT_W'(1));
                    end
                    else if (left == CNT_W'(1))
                    begin
                        rpt.valid = 1'b1;
                        if (cls == tow_pkg::CLS_UNKNOWN)
                        begin
                            rpt.ends_area = 1'b1;
                        end
                        else
                        begin
                            rpt.option_len = 8'd0;
                            rpt.status     = tow_pkg::ST_MISSING;
                        end
                    end
                end
            end
            tow_pkg::PH_LEN:
            begin
                rpt.option_kind = kind_reg;
                rpt.kind_class  = cls_reg;
                rpt.option_len  = beat.opt_byte;
                if (left != '0)
                begin
                    rpt.valid = 1'b1;
                    if (beat.opt_byte < 8'd2)
                    begin
                        rpt.status = tow_pkg::ST_ZERO_LEN;
                    end
                    else if (beat.opt_byte > rem)
                    begin
                        rpt.status = tow_pkg::ST_EXCEEDS;
                    end
                    else
                    begin
                        rpt.ends_area = (beat.opt_byte == rem);
                    end
                end
            end
            default:
            begin
                rpt.valid = 1'b0;
            end
        endcase
        if (!beat.valid || empty_start)
        begin
            rpt.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tow_pkg::PH_IDLE;
            left_reg  <= '0;
            body_reg  <= 8'd0;
            kind_reg  <= 8'd0;
            cls_reg   <= tow_pkg::CLS_EOL;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            body_reg  <= body_next;
            kind_reg  <= kind_next;
            cls_reg   <= cls_next;
        end
    end

    // An idle walk has no bytes left to account for.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tow_pkg::PH_IDLE |-> left_reg == '0)
        else $error("idle walk with bytes left");

    // Body skipping always has a body byte pending within the area.
    a_body_fits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tow_pkg::PH_BODY |-> body_reg != 8'd0 && body_reg <= 8'(left_reg))
        else $error("body count out of range");

    // Any error report stops the walk.
    a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rpt.valid && rpt.status != tow_pkg::ST_OK |=> phase_reg == tow_pkg::PH_IDLE)
        else $error("walk continued after an error");

    // Only a clean option can close the area.
    a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rpt.valid && rpt.ends_area |-> rpt.status == tow_pkg::ST_OK)
        else $error("area end flagged on an error report");

endmodule

[rtl/tow_out_reg.sv]
// Output register that holds one option report until it is taken.
`timescale 1ns / 1ps

module tow_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  tow_pkg::rpt_t  rpt,
    input  logic           advance,
    output logic           can_take,
    tow_out_if.source      report
);

    logic                 valid_reg;
    logic                 valid_next;
    logic                 load;
    logic [7:0]           kind_reg;
    tow_pkg::kind_class_t cls_reg;
    logic [7:0]           len_reg;
    tow_pkg::status_t     status_reg;
    logic                 ends_reg;

    // The register can take a new report when empty or when its report leaves now.
    assign can_take = !valid_reg || report.ready;
    assign load     = advance && rpt.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= rpt.option_kind;
            cls_reg    <= rpt.kind_class;
            len_reg    <= rpt.option_len;
            status_reg <= rpt.status;
            ends_reg   <= rpt.ends_area;
        end
    end

    assign report.valid       = valid_reg;
    assign report.option_kind = kind_reg;
    assign report.kind_class  = cls_reg;
    assign report.option_len  = len_reg;
    assign report.status      = status_reg;
    assign report.ends_area   = ends_reg;

endmodule

[rtl/tcp_option_walker.sv]
// Top level of the TCP option walker.
`timescale 1ns / 1ps

// The opt channel brings the TCP option area one byte per beat. A beat with
// first_byte set starts a new area and is its first kind byte; area_len on that
// beat gives the area size and is clipped to MAX_OPT_BYTES. A zero size starts
// nothing. Bytes that arrive while no walk is active are dropped silently.
// The report channel carries at most one report per byte: on EOL, NOP and on
// the length byte of every longer option, plus the truncated last-byte cases.
// A report with a non-zero status ends the walk until the next start byte.
// A byte's report is formed by the walk logic from the input register and
// loaded into the report register as the byte leaves it. Throughput is one
// byte per cycle while the receiver takes reports, set by the single input
// register and the single report register with the walk logic between them.
// When the receiver stalls, the report register holds its beat; the input
// register still fills, and a byte that needs to report waits there, which
// lowers opt.ready. Bytes that report nothing still flow through in a stall.
// Reset (rst_n low, asynchronous) empties both registers and idles the walk.

module tcp_option_walker #(
    parameter int MAX_OPT_BYTES = tow_pkg::MAX_OPT_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tow_in_if.sink     opt,
    tow_out_if.source  report
);

    tow_pkg::beat_t beat;
    tow_pkg::rpt_t  rpt;
    logic           can_take;
    logic           advance;

    // A byte leaves the input register when it reports nothing or its report
    // has room in the output register.
    assign advance = beat.valid && (!rpt.valid || can_take);

    tow_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .opt     (opt),
        .advance (advance),
        .beat    (beat)
    );

    tow_walker #(
        .MAX_OPT_BYTES (MAX_OPT_BYTES)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .advance (advance),
        .rpt     (rpt)
    );

    tow_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .rpt      (rpt),
        .advance  (advance),
        .can_take (can_take),
        .report   (report)
    );

endmodule
